// File: sv/sumono_pkg.sv
`default_nettype none

package sumono_pkg;

  // Configuration register indexes, in the order of the register map.
  typedef enum logic [2:0] {
    CFG_GAIN   = 3'd0,
    CFG_PAN    = 3'd1,
    CFG_WIDTH  = 3'd2,
    CFG_ALPHA  = 3'd3,
    CFG_MONO   = 3'd4,
    CFG_LMONO  = 3'd5,
    CFG_INV_L  = 3'd6,
    CFG_INV_R  = 3'd7
  } cfg_idx_t;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 18;
  localparam int GAIN_BITS     = 18;
  localparam int PAN_BITS      = 17;
  localparam int WIDTH_BITS    = 16;
  localparam int ALPHA_BITS    = 16;
  localparam int PAN_GAIN_BITS = 16;

  // Coefficient operand of the shared multiplier: every coefficient is
  // unsigned and at most 18 bits, so one sign bit on top covers them all.
  localparam int MUL_B_BITS = 19;

  // Register defaults.
  localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = 18'd65536;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 16'd16384;
  localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 16'd1023;

  // Width saturates at 2.0 in Q2.14; pan saturates at +-1.0 in Q1.15.
  localparam logic [WIDTH_BITS-1:0]        WIDTH_MAX    = 16'd32768;
  localparam logic signed [PAN_BITS-1:0]   PAN_POS      = 17'sd32768;
  localparam logic signed [PAN_BITS-1:0]   PAN_NEG      = -17'sd32768;
  localparam logic [PAN_GAIN_BITS-1:0]     PAN_UNITY    = 16'h8000;

  // Rounding shift applied to the registered product.
  typedef enum logic [1:0] {
    RND_Q14 = 2'd0,
    RND_Q15 = 2'd1,
    RND_Q16 = 2'd2
  } rnd_t;

  // Control handed to the multiplier each cycle.
  typedef struct packed {
    logic en;
    rnd_t rnd;
  } mac_ctl_t;

endpackage

`default_nettype wire

// File: sv/sumono_mac.sv
`default_nettype none

module sumono_mac #(
  parameter int A_BITS = 37
) (
  input  wire logic                                          clk,
  input  wire sumono_pkg::mac_ctl_t                          ctl,
  input  wire logic signed [A_BITS-1:0]                      mul_a,
  input  wire logic signed [sumono_pkg::MUL_B_BITS-1:0]      mul_b,
  output logic signed [A_BITS+sumono_pkg::MUL_B_BITS-1:0]    rnd
);

  localparam int P_BITS = A_BITS + sumono_pkg::MUL_B_BITS;

  localparam logic signed [P_BITS-1:0] HALF_Q14 = {{(P_BITS-14){1'b0}}, 1'b1, 13'b0};
  localparam logic signed [P_BITS-1:0] HALF_Q15 = {{(P_BITS-15){1'b0}}, 1'b1, 14'b0};
  localparam logic signed [P_BITS-1:0] HALF_Q16 = {{(P_BITS-16){1'b0}}, 1'b1, 15'b0};

  logic signed [P_BITS-1:0] prod_r;
  sumono_pkg::rnd_t         shift_r;

  // Product and its rounding code are captured together.
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r  <= mul_a * mul_b;
      shift_r <= ctl.rnd;
    end
  end

  // Round half up, then floor: add half an LSB and shift arithmetically.
  always_comb begin
    case (shift_r)
      sumono_pkg::RND_Q14: rnd = (prod_r + HALF_Q14) >>> 14;
      sumono_pkg::RND_Q15: rnd = (prod_r + HALF_Q15) >>> 15;
      sumono_pkg::RND_Q16: rnd = (prod_r + HALF_Q16) >>> 16;
      default:             rnd = prod_r;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/stereo_utility_low_mono_top.sv
// A new input beat is accepted only in the idle state, after the previous beat has been handed
// to the output register; every gain, width, filter and pan product goes through the one
// shared multiplier, one product a cycle.
// A finished result waits in the output register while the next beat is taken.
// Reset (rst_n low, synchronous) restores the register defaults, zeroes the four
// lowpass states and empties the output register.
`default_nettype none

module stereo_utility_low_mono_top #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     in_valid,
  output logic                                          in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]            in_sample_left,
  input  wire logic signed [SAMPLE_BITS-1:0]            in_sample_right,
  input  wire logic                                     in_right_present,
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output logic signed [SAMPLE_BITS-1:0]                 out_left,
  output logic signed [SAMPLE_BITS-1:0]                 out_right,
  input  wire logic                                     cfg_we,
  input  wire logic [sumono_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [sumono_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  // Widths: mid/side values, and the widest working value (filter and fold).
  localparam int W1    = SAMPLE_BITS + 4;
  localparam int WBASE = (SAMPLE_BITS + 6 > 33) ? SAMPLE_BITS + 6 : 33;
  localparam int W3    = WBASE + 2;
  localparam int MB    = sumono_pkg::MUL_B_BITS;

  localparam logic signed [W3-1:0] ONE_W = {{(W3-1){1'b0}}, 1'b1};
  localparam logic signed [W3-1:0] OUT_MAX = {{(W3-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [W3-1:0] OUT_MIN = {{(W3-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [W3-1:0] ST_MAX  = {{(W3-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [W3-1:0] ST_MIN  = {{(W3-31){1'b1}}, {31{1'b0}}};

  typedef enum logic [4:0] {
    ST_IDLE, ST_GAIN_L, ST_GAIN_R, ST_GAIN_END, ST_SPLIT, ST_WIDTH, ST_REBUILD,
    ST_P1_DIFF, ST_P1_L, ST_P1_R, ST_P2_DIFF, ST_P2_L, ST_P2_R, ST_P2_END, ST_FOLD,
    ST_PAN_L, ST_PAN_R, ST_PAN_END, ST_DONE
  } state_t;

  // Configuration registers.
  logic [sumono_pkg::GAIN_BITS-1:0]         gain_r;
  logic signed [sumono_pkg::PAN_BITS-1:0]   pan_r;
  logic [sumono_pkg::WIDTH_BITS-1:0]        width_r;
  logic [sumono_pkg::ALPHA_BITS-1:0]        alpha_r;
  logic                                     mono_r;
  logic                                     lmono_r;
  logic                                     inv_l_r;
  logic                                     inv_r_r;

  // Sequencer, datapath and output registers.
  state_t                         state_r, state_nxt;
  logic signed [SAMPLE_BITS:0]    sl_r, sl_nxt, sr_r, sr_nxt;
  logic signed [W3-1:0]           l_r, l_nxt, r_r, r_nxt, diff_r, diff_nxt;
  logic signed [W1-1:0]           mid_r, mid_nxt, side_r, side_nxt;
  logic signed [31:0]             st_l1_r, st_l1_nxt, st_l2_r, st_l2_nxt;
  logic signed [31:0]             st_r1_r, st_r1_nxt, st_r2_r, st_r2_nxt;
  logic signed [SAMPLE_BITS-1:0]  res_l_r, res_l_nxt, res_r_r, res_r_nxt;
  logic signed [SAMPLE_BITS-1:0]  out_left_r, out_left_nxt, out_right_r, out_right_nxt;
  logic                           out_valid_r, out_valid_nxt;

  // Shared multiplier interface.
  sumono_pkg::mac_ctl_t           mac_ctl;
  logic signed [W3-1:0]           mac_a;
  logic signed [MB-1:0]           mac_b;
  logic signed [W3+MB-1:0]        mac_rnd;
  logic signed [W3-1:0]           prod_w;

  // Input sample selection and polarity.
  logic signed [SAMPLE_BITS:0]    sl_in, sr_in;

  // Clamped coefficients.
  logic [sumono_pkg::WIDTH_BITS-1:0]        w_clamp;
  logic signed [sumono_pkg::PAN_BITS-1:0]   pan_c, gl_diff, gr_sum;
  logic [sumono_pkg::PAN_GAIN_BITS-1:0]     gl, gr;

  // Shared adders for mid/side and the bass fold.
  logic signed [W3-1:0]           mid_sum, side_sum, low_mid;

  function automatic logic signed [W3-1:0] ext32(input logic signed [31:0] v);
    ext32 = {{(W3-32){v[31]}}, v};
  endfunction

  function automatic logic signed [W3-1:0] ext1(input logic signed [W1-1:0] v);
    ext1 = {{(W3-W1){v[W1-1]}}, v};
  endfunction

  // One lowpass update: state plus rounded step, saturated to 32 bits.
  function automatic logic signed [31:0] pole_upd(input logic signed [31:0] st,
                                                  input logic signed [W3-1:0] step);
    logic signed [W3-1:0] sum;
    sum = ext32(st) + step;
    if (sum > ST_MAX) begin
      pole_upd = ST_MAX[31:0];
    end else if (sum < ST_MIN) begin
      pole_upd = ST_MIN[31:0];
    end else begin
      pole_upd = sum[31:0];
    end
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_out(input logic signed [W3-1:0] v);
    if (v > OUT_MAX) begin
      sat_out = OUT_MAX[SAMPLE_BITS-1:0];
    end else if (v < OUT_MIN) begin
      sat_out = OUT_MIN[SAMPLE_BITS-1:0];
    end else begin
      sat_out = v[SAMPLE_BITS-1:0];
    end
  endfunction

  sumono_mac #(
    .A_BITS (W3)
  ) u_mac (
    .clk   (clk),
    .ctl   (mac_ctl),
    .mul_a (mac_a),
    .mul_b (mac_b),
    .rnd   (mac_rnd)
  );

  assign prod_w = mac_rnd[W3-1:0];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= sumono_pkg::GAIN_RESET;
      pan_r   <= '0;
      width_r <= sumono_pkg::WIDTH_RESET;
      alpha_r <= sumono_pkg::ALPHA_RESET;
      mono_r  <= 1'b0;
      lmono_r <= 1'b0;
      inv_l_r <= 1'b0;
      inv_r_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sumono_pkg::CFG_GAIN:  gain_r  <= cfg_data[sumono_pkg::GAIN_BITS-1:0];
        sumono_pkg::CFG_PAN:   pan_r   <= cfg_data[sumono_pkg::PAN_BITS-1:0];
        sumono_pkg::CFG_WIDTH: width_r <= cfg_data[sumono_pkg::WIDTH_BITS-1:0];
        sumono_pkg::CFG_ALPHA: alpha_r <= cfg_data[sumono_pkg::ALPHA_BITS-1:0];
        sumono_pkg::CFG_MONO:  mono_r  <= cfg_data[0];
        sumono_pkg::CFG_LMONO: lmono_r <= cfg_data[0];
        sumono_pkg::CFG_INV_L: inv_l_r <= cfg_data[0];
        sumono_pkg::CFG_INV_R: inv_r_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Width and pan clamps, and the far-side pan attenuation.
  always_comb begin
    w_clamp = (width_r > sumono_pkg::WIDTH_MAX) ? sumono_pkg::WIDTH_MAX : width_r;
    if (pan_r > sumono_pkg::PAN_POS) begin
      pan_c = sumono_pkg::PAN_POS;
    end else if (pan_r < sumono_pkg::PAN_NEG) begin
      pan_c = sumono_pkg::PAN_NEG;
    end else begin
      pan_c = pan_r;
    end
    gl_diff = sumono_pkg::PAN_POS - pan_c;
    gr_sum  = sumono_pkg::PAN_POS + pan_c;
    gl = (pan_c <= 0) ? sumono_pkg::PAN_UNITY : gl_diff[sumono_pkg::PAN_GAIN_BITS-1:0];
    gr = (pan_c >= 0) ? sumono_pkg::PAN_UNITY : gr_sum[sumono_pkg::PAN_GAIN_BITS-1:0];
  end

  // Input polarity; a missing right channel reuses the left sample.
  always_comb begin
    sl_in = {in_sample_left[SAMPLE_BITS-1], in_sample_left};
    sr_in = in_right_present ? {in_sample_right[SAMPLE_BITS-1], in_sample_right} : sl_in;
    if (inv_l_r) begin
      sl_in = -sl_in;
    end
    if (inv_r_r) begin
      sr_in = -sr_in;
    end
  end

  // Mid/side split and the averaged bass, each rounded half up.
  always_comb begin
    mid_sum  = (l_r + r_r + ONE_W) >>> 1;
    side_sum = (l_r - r_r + ONE_W) >>> 1;
    low_mid  = (ext32(st_l2_r) + ext32(st_r2_r) + ONE_W) >>> 1;
  end

  // Sequencer: at most one multiplier product issued and one consumed per step.
  always_comb begin
    state_nxt     = state_r;
    sl_nxt        = sl_r;
    sr_nxt        = sr_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    diff_nxt      = diff_r;
    mid_nxt       = mid_r;
    side_nxt      = side_r;
    st_l1_nxt     = st_l1_r;
    st_l2_nxt     = st_l2_r;
    st_r1_nxt     = st_r1_r;
    st_r2_nxt     = st_r2_r;
    res_l_nxt     = res_l_r;
    res_r_nxt     = res_r_r;
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mac_ctl.en    = 1'b0;
    mac_ctl.rnd   = sumono_pkg::RND_Q16;
    mac_a         = '0;
    mac_b         = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          sl_nxt    = sl_in;
          sr_nxt    = sr_in;
          state_nxt = ST_GAIN_L;
        end
      end
      ST_GAIN_L: begin
        mac_ctl.en = 1'b1;
        mac_a      = {{(W3-SAMPLE_BITS-1){sl_r[SAMPLE_BITS]}}, sl_r};
        mac_b      = {1'b0, gain_r};
        state_nxt  = ST_GAIN_R;
      end
      ST_GAIN_R: begin
        mac_ctl.en = 1'b1;
        mac_a      = {{(W3-SAMPLE_BITS-1){sr_r[SAMPLE_BITS]}}, sr_r};
        mac_b      = {1'b0, gain_r};
        l_nxt      = prod_w;
        state_nxt  = ST_GAIN_END;
      end
      ST_GAIN_END: begin
        r_nxt     = prod_w;
        state_nxt = ST_SPLIT;
      end
      ST_SPLIT: begin
        mid_nxt   = mid_sum[W1-1:0];
        side_nxt  = side_sum[W1-1:0];
        state_nxt = ST_WIDTH;
      end
      ST_WIDTH: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.rnd = sumono_pkg::RND_Q14;
        mac_a       = ext1(side_r);
        mac_b       = {{(MB-sumono_pkg::WIDTH_BITS){1'b0}}, w_clamp};
        state_nxt   = ST_REBUILD;
      end
      ST_REBUILD: begin
        if (mono_r) begin
          l_nxt = ext1(mid_r);
          r_nxt = ext1(mid_r);
        end else begin
          l_nxt = ext1(mid_r) + prod_w;
          r_nxt = ext1(mid_r) - prod_w;
        end
        state_nxt = (!mono_r && lmono_r) ? ST_P1_DIFF : ST_PAN_L;
      end
      // First lowpass of each channel, interleaved left then right.
      ST_P1_DIFF: begin
        diff_nxt  = l_r - ext32(st_l1_r);
        state_nxt = ST_P1_L;
      end
      ST_P1_L: begin
        mac_ctl.en = 1'b1;
        mac_a      = diff_r;
        mac_b      = {{(MB-sumono_pkg::ALPHA_BITS){1'b0}}, alpha_r};
        diff_nxt   = r_r - ext32(st_r1_r);
        state_nxt  = ST_P1_R;
      end
      ST_P1_R: begin
        mac_ctl.en = 1'b1;
        mac_a      = diff_r;
        mac_b      = {{(MB-sumono_pkg::ALPHA_BITS){1'b0}}, alpha_r};
        st_l1_nxt  = pole_upd(st_l1_r, prod_w);
        state_nxt  = ST_P2_DIFF;
      end
      // Second lowpass, fed by the first.
      ST_P2_DIFF: begin
        st_r1_nxt = pole_upd(st_r1_r, prod_w);
        diff_nxt  = ext32(st_l1_r) - ext32(st_l2_r);
        state_nxt = ST_P2_L;
      end
      ST_P2_L: begin
        mac_ctl.en = 1'b1;
        mac_a      = diff_r;
        mac_b      = {{(MB-sumono_pkg::ALPHA_BITS){1'b0}}, alpha_r};
        diff_nxt   = ext32(st_r1_r) - ext32(st_r2_r);
        state_nxt  = ST_P2_R;
      end
      ST_P2_R: begin
        mac_ctl.en = 1'b1;
        mac_a      = diff_r;
        mac_b      = {{(MB-sumono_pkg::ALPHA_BITS){1'b0}}, alpha_r};
        st_l2_nxt  = pole_upd(st_l2_r, prod_w);
        state_nxt  = ST_P2_END;
      end
      ST_P2_END: begin
        st_r2_nxt = pole_upd(st_r2_r, prod_w);
        state_nxt = ST_FOLD;
      end
      // Swap each channel's bass for the average bass of both.
      ST_FOLD: begin
        l_nxt     = low_mid + l_r - ext32(st_l2_r);
        r_nxt     = low_mid + r_r - ext32(st_r2_r);
        state_nxt = ST_PAN_L;
      end
      ST_PAN_L: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.rnd = sumono_pkg::RND_Q15;
        mac_a       = l_r;
        mac_b       = {{(MB-sumono_pkg::PAN_GAIN_BITS){1'b0}}, gl};
        state_nxt   = ST_PAN_R;
      end
      ST_PAN_R: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.rnd = sumono_pkg::RND_Q15;
        mac_a       = r_r;
        mac_b       = {{(MB-sumono_pkg::PAN_GAIN_BITS){1'b0}}, gr};
        res_l_nxt   = sat_out(prod_w);
        state_nxt   = ST_PAN_END;
      end
      ST_PAN_END: begin
        res_r_nxt = sat_out(prod_w);
        state_nxt = ST_DONE;
      end
      // Hand the result over once the output register is free.
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_left_nxt  = res_l_r;
          out_right_nxt = res_r_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, filter state, datapath and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      st_l1_r     <= '0;
      st_l2_r     <= '0;
      st_r1_r     <= '0;
      st_r2_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      st_l1_r     <= st_l1_nxt;
      st_l2_r     <= st_l2_nxt;
      st_r1_r     <= st_r1_nxt;
      st_r2_r     <= st_r2_nxt;
    end
    sl_r        <= sl_nxt;
    sr_r        <= sr_nxt;
    l_r         <= l_nxt;
    r_r         <= r_nxt;
    diff_r      <= diff_nxt;
    mid_r       <= mid_nxt;
    side_r      <= side_nxt;
    res_l_r     <= res_l_nxt;
    res_r_r     <= res_r_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;

endmodule

`default_nettype wire

// File: sv/sumono_chk.sv
`default_nettype none

module sumono_chk #(
  parameter int SAMPLE_BITS = 24
) (
  input wire logic                                  clk,
  input wire logic                                  rst_n,
  input wire logic                                  in_valid,
  input wire logic                                  in_ready,
  input wire logic                                  out_valid,
  input wire logic                                  out_ready,
  input wire logic signed [SAMPLE_BITS-1:0]         out_left,
  input wire logic signed [SAMPLE_BITS-1:0]         out_right
);

  logic       in_acc, out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Beats taken in but not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // After reset the block is empty and takes input.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not empty after reset");

  // One beat is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input taken while a beat is in work");

  // At most one beat in work and one waiting in the output register.
  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 2'd2)
    else $error("more than two beats outstanding");

  // A result only ever comes from an accepted beat.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without an accepted beat");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right))
    else $error("stalled result changed");

endmodule

bind stereo_utility_low_mono_top sumono_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_sumono_chk (.*);

`default_nettype wire
